// ===== hdl/ukt_pkg.sv =====
// Shared types and constants for the unique key table.
// Used by ukt_mem and unique_key_table_compacting; no dependencies.
`default_nettype none

package ukt_pkg;

  localparam int KEY_W        = 64;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 3;
  localparam int POS_W        = 6;
  localparam int RESULT_LIMIT = 64;
  // position + entry_key, padded to whole bytes
  localparam int OUT_DATA_W   = ((POS_W + KEY_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LIST   = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/unique_key_table_compacting.sv =====
// Top level of the compacting unique key table: sequencer, count and output register.
// Depends on ukt_pkg and ukt_mem.
//
//  channel   dir  beat contents
//  s_axis    in   tuser = operation, tdata = key
//  m_axis    out  tuser = status, tdata = {pad, entry_key, position}, tlast = last
//
// One item at a time; s_axis_tready is high only while the sequencer is idle.
// Add: the key is checked against each stored entry, one key compare per cycle off the RAM read port.
// Delete: search as for add, then each entry after the hit moves down one place.
// List: one beat per cycle while m_axis_tready stays high.
// All three operations share the single RAM read port. A stalled m_axis holds the list
// walk; the output register lets the next item enter while a beat waits.
// Synchronous reset clears the count, state, pending flag and output valid; no clearing pass over the key RAM.
`default_nettype none

module unique_key_table_compacting
  import ukt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [KEY_W-1:0]      s_axis_tdata,  // [63:0] key
  input  wire logic [OP_W-1:0]       s_axis_tuser,  // [1:0] operation
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [5:0] position, [69:6] entry_key
  output logic [STATUS_W-1:0]        m_axis_tuser,  // [2:0] status
  output logic                       m_axis_tlast
);

  localparam int AW       = $clog2(TABLE_DEPTH);
  localparam int CW       = $clog2(TABLE_DEPTH + 1);
  localparam int LIST_MAX = (TABLE_DEPTH < RESULT_LIMIT) ? TABLE_DEPTH : RESULT_LIMIT;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] LIST_C  = CW'(LIST_MAX);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_LIST   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t         state, state_next;
  op_t            op_q, op_q_next;
  logic [KEY_W-1:0] key_q, key_q_next;
  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  idx, idx_next;
  logic           pend, pend_next;
  logic [CW-1:0]  pend_addr, pend_addr_next;
  logic [CW-1:0]  list_n, list_n_next;
  status_t        resp_status, resp_status_next;

  logic           out_valid;
  status_t        out_status;
  logic [POS_W-1:0] out_pos;
  logic [KEY_W-1:0] out_key;
  logic           out_last;

  logic           load_out;
  status_t        ld_status;
  logic [POS_W-1:0] ld_pos;
  logic [KEY_W-1:0] ld_key;
  logic           ld_last;

  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  logic [KEY_W-1:0] rd_data, wr_data;

  logic           out_free, consume;
  logic [CW-1:0]  pend_prev, pend_inc;

  ukt_mem #(
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign out_free  = !out_valid || m_axis_tready;
  assign consume   = pend && out_free;
  assign pend_prev = pend_addr - CW'(1);
  assign pend_inc  = pend_addr + CW'(1);

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {(OUT_DATA_W - POS_W - KEY_W)'(0), out_key, out_pos};

  always_comb begin
    state_next       = state;
    op_q_next        = op_q;
    key_q_next       = key_q;
    count_next       = count;
    idx_next         = idx;
    pend_next        = pend;
    pend_addr_next   = pend_addr;
    list_n_next      = list_n;
    resp_status_next = resp_status;
    rd_en            = 1'b0;
    rd_addr          = idx[AW-1:0];
    wr_en            = 1'b0;
    wr_addr          = count[AW-1:0];
    wr_data          = key_q;
    load_out         = 1'b0;
    ld_status        = ST_OK;
    ld_pos           = '0;
    ld_key           = '0;
    ld_last          = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_q_next  = op_t'(s_axis_tuser);
          key_q_next = s_axis_tdata;
          idx_next   = '0;
          pend_next  = 1'b0;
          unique case (s_axis_tuser)
            OP_ADD: begin
              if (count == DEPTH_C) begin
                resp_status_next = ST_FULL;
                state_next       = S_RESP;
              end else begin
                state_next = S_SEARCH;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                list_n_next = (count > LIST_C) ? LIST_C : count;
                state_next  = S_LIST;
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                resp_status_next = ST_EMPTY;
                state_next       = S_RESP;
              end else begin
                state_next = S_SEARCH;
              end
            end
            default: ;  // unused code: dropped, no beat
          endcase
        end
      end

      S_SEARCH: begin
        priority if (pend && rd_data == key_q) begin
          pend_next = 1'b0;
          if (op_q == OP_ADD) begin
            resp_status_next = ST_PRESENT;
            state_next       = S_RESP;
          end else begin
            idx_next   = pend_inc;
            state_next = S_SHIFT;
          end
        end else if (idx < count) begin
          // compare of the previous read overlaps the next read
          rd_en          = 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = idx;
          idx_next       = idx + CW'(1);
        end else if (!pend) begin
          if (op_q == OP_ADD) begin
            wr_en            = 1'b1;
            count_next       = count + CW'(1);
            resp_status_next = ST_OK;
          end else begin
            resp_status_next = ST_NOT_FOUND;
          end
          state_next = S_RESP;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_SHIFT: begin
        // entry read last cycle moves down one place
        if (pend) begin
          wr_en   = 1'b1;
          wr_addr = pend_prev[AW-1:0];
          wr_data = rd_data;
        end
        priority if (idx < count) begin
          rd_en          = 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = idx;
          idx_next       = idx + CW'(1);
        end else if (!pend) begin
          count_next       = count - CW'(1);
          resp_status_next = ST_OK;
          state_next       = S_RESP;
        end else begin
          pend_next = 1'b0;
        end
      end

      S_LIST: begin
        if (consume) begin
          load_out  = 1'b1;
          ld_status = ST_OK;
          ld_pos    = POS_W'(pend_addr);
          ld_key    = rd_data;
          ld_last   = (pend_inc == list_n);
          pend_next = 1'b0;
        end
        if (!pend || consume) begin
          if (idx < list_n) begin
            rd_en          = 1'b1;
            pend_next      = 1'b1;
            pend_addr_next = idx;
            idx_next       = idx + CW'(1);
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          ld_status  = resp_status;
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q        <= op_q_next;
    key_q       <= key_q_next;
    idx         <= idx_next;
    pend_addr   <= pend_addr_next;
    list_n      <= list_n_next;
    resp_status <= resp_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= ld_status;
      out_pos    <= ld_pos;
      out_key    <= ld_key;
      out_last   <= ld_last;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ukt_mem.sv =====
// Key store: simple dual-port RAM, one write and one registered read port.
// Depends on ukt_pkg for the key width.
`default_nettype none

module ukt_mem
  import ukt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [KEY_W-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [KEY_W-1:0]         wr_data
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for unique_key_table_compacting: random bursts of add, delete and list
// beats against an in-bench table predictor, with random output back-pressure.
// Depends on ukt_pkg and the unique_key_table_compacting RTL.
`timescale 1ns / 100ps

module tb_top;
  import ukt_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 370;
  localparam int CHOKE_CYCLES = 300;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    bit               hold;   // wait for all results before offering
    bit               choke;  // receiver holds off once this beat is taken
  } table_cmd_t;

  typedef struct packed {
    status_t            status;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   entry_key;
    logic               last;
  } result_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [KEY_W-1:0]      s_axis_tdata = '0;  // [63:0] key
  logic [OP_W-1:0]       s_axis_tuser = '0;  // [1:0] operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // [5:0] position, [69:6] entry_key
  logic [STATUS_W-1:0]   m_axis_tuser;       // [2:0] status
  logic                  m_axis_tlast;

  // predicted table contents
  logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
  int               tbl_count = 0;
  result_beat_t     beats_due[$];

  // stimulus side
  table_cmd_t       cmd_queue[$];
  table_cmd_t       cur_cmd;
  logic [KEY_W-1:0] gen_keys[$];  // keys the stimulus expects to be stored
  int               stim_items = 0;

  int errors = 0;
  bit taken = 1'b0;
  int chokes_seen = 0;
  int chokes_served = 0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;

  unique_key_table_compacting #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk = ~clk;

  function automatic void post_beat(status_t st, logic [POS_W-1:0] pos,
                                    logic [KEY_W-1:0] k, logic fin);
    beats_due.push_back('{st, pos, k, fin});
  endfunction

  task automatic apply_to_table(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    int hit;
    int n;
    hit = -1;
    for (int i = 0; i < tbl_count; i++)
      if (hit < 0 && tbl_keys[i] == key) hit = i;
    case (op)
      OP_ADD: begin
        // full wins over duplicate
        if (tbl_count >= TABLE_DEPTH) post_beat(ST_FULL, '0, '0, 1'b1);
        else if (hit >= 0) post_beat(ST_PRESENT, '0, '0, 1'b1);
        else begin
          tbl_keys[tbl_count] = key;
          tbl_count++;
          post_beat(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_LIST: begin
        if (tbl_count == 0) post_beat(ST_EMPTY, '0, '0, 1'b1);
        else begin
          n = (tbl_count > RESULT_LIMIT) ? RESULT_LIMIT : tbl_count;
          for (int i = 0; i < n; i++)
            post_beat(ST_OK, POS_W'(i), tbl_keys[i], i == n - 1);
        end
      end
      OP_DELETE: begin
        if (tbl_count == 0) post_beat(ST_EMPTY, '0, '0, 1'b1);
        else if (hit < 0) post_beat(ST_NOT_FOUND, '0, '0, 1'b1);
        else begin
          for (int i = hit; i + 1 < tbl_count; i++) tbl_keys[i] = tbl_keys[i + 1];
          tbl_count--;
          post_beat(ST_OK, '0, '0, 1'b1);
        end
      end
      default: ;  // unused code: dropped
    endcase
  endtask

  // ---------------- stimulus ----------------
  function automatic logic [KEY_W-1:0] fresh_key();
    case ($urandom_range(0, 9))
      0: return KEY_W'($urandom_range(0, 15));
      1: return ~KEY_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] stored_key();
    if (gen_keys.size() == 0) return fresh_key();
    return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
  endfunction

  task automatic add_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input bit hold = 1'b0, input bit choke = 1'b0);
    int idx;
    idx = -1;
    foreach (gen_keys[i]) if (gen_keys[i] == key) idx = i;
    cmd_queue.push_back('{op, key, hold, choke});
    if (op == OP_ADD && idx < 0 && gen_keys.size() < TABLE_DEPTH) gen_keys.push_back(key);
    if (op == OP_DELETE && idx >= 0) gen_keys.delete(idx);
    stim_items++;
  endtask

  // kind 0 grows the table, 1 shrinks it, 2 churns
  task automatic random_cmd(input int kind, input bit hold);
    int r;
    int a_new, a_dup, d_hit, d_miss;
    r = $urandom_range(0, 99);
    case (kind)
      0:       begin a_new = 60; a_dup = 70; d_hit = 85; d_miss = 90; end
      1:       begin a_new = 20; a_dup = 25; d_hit = 75; d_miss = 85; end
      default: begin a_new = 40; a_dup = 48; d_hit = 80; d_miss = 86; end
    endcase
    if (r < 3) add_cmd(OP_UNUSED, fresh_key(), hold);
    else if (r < a_new) add_cmd(OP_ADD, fresh_key(), hold);
    else if (r < a_dup) add_cmd(OP_ADD, stored_key(), hold);
    else if (r < d_hit) add_cmd(OP_DELETE, stored_key(), hold);
    else if (r < d_miss) add_cmd(OP_DELETE, fresh_key(), hold);
    else add_cmd(OP_LIST, fresh_key(), hold);
  endtask

  initial begin : stimulus
    int kind;
    int len;
    // directed corner cases
    add_cmd(OP_LIST, '1);
    add_cmd(OP_DELETE, '1);
    add_cmd(OP_ADD, '0);
    add_cmd(OP_ADD, '1);
    add_cmd(OP_ADD, '0);
    add_cmd(OP_ADD, 64'h0123_4567_89ab_cdef);
    add_cmd(OP_LIST, 64'h5555_5555_5555_5555);
    add_cmd(OP_DELETE, 64'h5555_5555_5555_5555);
    add_cmd(OP_DELETE, '0);  // head entry, rest shift down
    add_cmd(OP_UNUSED, 64'haaaa_aaaa_aaaa_aaaa);
    add_cmd(OP_UNUSED, '1);
    add_cmd(OP_LIST, '0);
    add_cmd(OP_DELETE, 64'h0123_4567_89ab_cdef);  // tail entry
    add_cmd(OP_DELETE, '1);
    add_cmd(OP_LIST, 64'haaaa_aaaa_aaaa_aaaa);
    add_cmd(OP_DELETE, '0);

    // fill to the top, then hit the full case (also with a stored key)
    add_cmd(OP_ADD, fresh_key(), 1'b1);
    while (gen_keys.size() < TABLE_DEPTH) add_cmd(OP_ADD, fresh_key());
    add_cmd(OP_ADD, fresh_key());
    add_cmd(OP_ADD, stored_key());
    add_cmd(OP_LIST, fresh_key(), 1'b0, 1'b1);  // full list under a long hold-off
    while (gen_keys.size() > 0) add_cmd(OP_DELETE, stored_key());
    add_cmd(OP_DELETE, fresh_key());
    add_cmd(OP_LIST, fresh_key());

    while (stim_items < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 2);
      len = $urandom_range(15, 45);
      for (int j = 0; j < len && stim_items < RANDOM_ITEMS; j++) random_cmd(kind, j == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (cmd_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && beats_due.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------- driver: bursts with random gaps ----------------
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_queue.size() == 0 || (cmd_queue[0].hold && beats_due.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        cur_cmd = cmd_queue.pop_front();
        s_axis_tdata  <= cur_cmd.key;
        s_axis_tuser  <= cur_cmd.op;
        s_axis_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          case ($urandom_range(0, 4))
            0: begin burst_left = $urandom_range(30, 60); gap_left = 0; end
            1: begin burst_left = $urandom_range(1, 3); gap_left = $urandom_range(1, 8); end
            2: begin burst_left = $urandom_range(1, 6); gap_left = $urandom_range(20, 40); end
            default: begin burst_left = $urandom_range(1, 12); gap_left = $urandom_range(0, 4); end
          endcase
        end
      end
    end
  end

  // ---------------- receiver back-pressure ----------------
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (chokes_served != chokes_seen) begin
        chokes_served++;
        hold_left = CHOKE_CYCLES;
      end
      if (rx_mode_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 120);
      end
      rx_mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          2: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= !m_axis_tready;
        endcase
      end
    end
  end

  // ---------------- monitor: check result beats, then predict taken items ----------------
  always @(posedge clk) begin : monitor
    result_beat_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected result beat: status %0d tdata %h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        due = beats_due.pop_front();
        if (m_axis_tuser !== due.status) begin
          $error("status: expected %0d, got %0d", due.status, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[POS_W-1:0] !== due.position) begin
          $error("position: expected %0d, got %0d", due.position, m_axis_tdata[POS_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[POS_W +: KEY_W] !== due.entry_key) begin
          $error("entry_key: expected %h, got %h", due.entry_key,
                 m_axis_tdata[POS_W +: KEY_W]);
          errors++;
        end
        if (m_axis_tlast !== due.last) begin
          $error("last: expected %0b, got %0b", due.last, m_axis_tlast);
          errors++;
        end
      end
    end
    taken = !rst && s_axis_tvalid && s_axis_tready;
    if (taken) begin
      apply_to_table(cur_cmd.op, cur_cmd.key);
      if (cur_cmd.choke) chokes_seen++;
    end
  end

endmodule
